// File: src/scb_pkg.sv
`timescale 1ns / 1ps
// shared types, constants and the bar colour table of the colour bar generator
package scb_pkg;

    localparam int DIM_W       = 13;
    localparam int MAX_WIDTH   = 4096;
    localparam int MAX_HEIGHT  = 4096;
    localparam int BAR_MAX     = 4096;
    localparam int STEP_W      = 8;
    localparam int FN_W        = 32;
    localparam int PAIR_W      = 11;
    localparam int ROW_W       = 12;
    localparam int SCROLL_W    = 15;
    localparam int OFFSET_W    = 25;
    localparam int DVD_W       = FN_W + STEP_W;
    localparam int DIV_STEPS   = DVD_W;
    localparam int DCNT_W      = $clog2(DIV_STEPS);
    localparam int CFG_IDX_W   = 2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BAR_WIDTH    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SCROLL_STEP  = 2'd3;

    // input word actions
    localparam logic ACT_START = 1'b0;
    localparam logic ACT_BEAT  = 1'b1;

    // output planes
    localparam logic PLANE_LUMA   = 1'b0;
    localparam logic PLANE_CHROMA = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV_START,
        S_DIV_RESYNC,
        S_FIN_START,
        S_FIN_RESYNC
    } t_state;

    typedef struct packed {
        logic accept_start;
        logic accept_beat;
        logic div_load_resync;
        logic div_step;
        logic fin_start;
        logic fin_resync;
    } t_cmd;

    typedef struct packed {
        logic active;
        logic dirty;
        logic div_done;
        logic out_free;
    } t_status;

    typedef struct packed {
        logic [ROW_W-1:0]  pairs;
        logic [DIM_W-1:0]  rows_luma;
        logic [ROW_W-1:0]  rows_chroma;
        logic [DIM_W-1:0]  bar_w;
        logic [STEP_W-1:0] scroll_step;
        logic              bar_w_wr;
    } t_geom;

    typedef struct packed {
        logic [7:0] y;
        logic [7:0] u;
        logic [7:0] v;
    } t_yuv;

    // bt.601 integer conversion of the eight bar colours, worked out offline
    function automatic t_yuv bar_colour(input logic [2:0] idx);
        t_yuv c;
        unique case (idx)
            3'd0:    c = '{y: 8'd218, u: 8'd128, v: 8'd128};
            3'd1:    c = '{y: 8'd197, u: 8'd32,  v: 8'd143};
            3'd2:    c = '{y: 8'd161, u: 8'd161, v: 8'd32};
            3'd3:    c = '{y: 8'd140, u: 8'd65,  v: 8'd48};
            3'd4:    c = '{y: 8'd108, u: 8'd191, v: 8'd208};
            3'd5:    c = '{y: 8'd86,  u: 8'd95,  v: 8'd224};
            3'd6:    c = '{y: 8'd51,  u: 8'd224, v: 8'd113};
            default: c = '{y: 8'd30,  u: 8'd128, v: 8'd128};
        endcase
        return c;
    endfunction

endpackage

// File: src/scb_ctrl.sv
`timescale 1ns / 1ps
// controller state machine of the colour bar generator
module scb_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic            i_action,
    output logic            o_in_ready,
    input  scb_pkg::t_status i_status,
    output scb_pkg::t_cmd    o_cmd
);
    import scb_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   w_resync_due;

    assign w_resync_due = i_status.active && i_status.dirty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_resync_due) begin
                    n_state = S_DIV_RESYNC;
                end else if (o_cmd.accept_start) begin
                    n_state = S_DIV_START;
                end
            end
            S_DIV_START: begin
                if (i_status.div_done) begin
                    n_state = S_FIN_START;
                end
            end
            S_DIV_RESYNC: begin
                if (i_status.div_done) begin
                    n_state = S_FIN_RESYNC;
                end
            end
            S_FIN_START:  n_state = S_IDLE;
            S_FIN_RESYNC: n_state = S_IDLE;
            default:      n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        o_cmd      = '0;
        unique case (r_state)
            S_IDLE: begin
                if (w_resync_due) begin
                    o_cmd.div_load_resync = 1'b1;
                end else begin
                    o_in_ready = i_status.out_free;
                    o_cmd.accept_start = o_in_ready && i_in_valid && (i_action == ACT_START);
                    o_cmd.accept_beat  = o_in_ready && i_in_valid && (i_action == ACT_BEAT);
                end
            end
            S_DIV_START, S_DIV_RESYNC: begin
                o_cmd.div_step = 1'b1;
            end
            S_FIN_START: begin
                o_cmd.fin_start = 1'b1;
            end
            S_FIN_RESYNC: begin
                o_cmd.fin_resync = 1'b1;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

endmodule

// File: src/scb_dp.sv
`timescale 1ns / 1ps
// datapath: frame counters, bar phase tracking, shared divider and output register
module scb_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  scb_pkg::t_cmd                 i_cmd,
    output scb_pkg::t_status              o_status,
    input  scb_pkg::t_geom                i_geom,
    input  logic [scb_pkg::FN_W-1:0]      i_frame_number,
    input  logic                          i_out_ready,
    output logic                          o_out_valid,
    output logic                          o_plane,
    output logic [scb_pkg::OFFSET_W-1:0]  o_byte_offset,
    output logic [7:0]                    o_first_byte,
    output logic [7:0]                    o_second_byte,
    output logic                          o_last_of_frame
);
    import scb_pkg::*;

    // control state
    logic r_active, n_active;
    logic r_chroma, n_chroma;
    logic r_dirty, n_dirty;
    logic r_svalid, n_svalid;
    logic r_out_valid, n_out_valid;
    logic [DCNT_W-1:0] r_dcnt, n_dcnt;

    // counters and phase
    logic [ROW_W-1:0]    r_row, n_row;
    logic [PAIR_W-1:0]   r_col, n_col;
    logic [SCROLL_W-1:0] r_scroll, n_scroll;
    logic [OFFSET_W-1:0] r_offset, n_offset;
    logic [2:0]          r_bar, n_bar;
    logic [DIM_W-1:0]    r_rem, n_rem;
    logic [2:0]          r_sbar, n_sbar;
    logic [DIM_W-1:0]    r_srem, n_srem;

    // divider
    logic [DVD_W-1:0] r_dvd, n_dvd;
    logic [DIM_W-1:0] r_drem, n_drem;
    logic [2:0]       r_dq, n_dq;
    logic [DIM_W-1:0] r_dbw, n_dbw;

    // output word
    logic                r_plane, n_plane;
    logic [OFFSET_W-1:0] r_ob_offset, n_ob_offset;
    logic [7:0]          r_first, n_first;
    logic [7:0]          r_second, n_second;
    logic                r_last, n_last;

    logic [ROW_W-1:0]    w_col_inc;
    logic [DIM_W-1:0]    w_row_inc;
    logic [DIM_W-1:0]    w_rows;
    logic                w_row_end;
    logic                w_plane_end;
    logic [DIM_W:0]      w_rem2;
    logic                w_bar_wrap;
    logic [DIM_W:0]      w_dt;
    logic [DIM_W:0]      w_dsub;
    logic                w_dge;
    logic [15:0]         w_scroll_sum;
    logic [15:0]         w_pos_sum;
    logic                w_beat;
    t_yuv                w_colour;

    assign w_beat      = i_cmd.accept_beat && r_active;
    assign w_col_inc   = {1'b0, r_col} + ROW_W'(1);
    assign w_row_inc   = {1'b0, r_row} + DIM_W'(1);
    assign w_rows      = r_chroma ? {1'b0, i_geom.rows_chroma} : i_geom.rows_luma;
    assign w_row_end   = w_col_inc >= i_geom.pairs;
    assign w_plane_end = w_row_end && (w_row_inc >= w_rows);
    assign w_rem2      = {1'b0, r_rem} + (DIM_W+1)'(2);
    assign w_bar_wrap  = w_rem2 >= {1'b0, i_geom.bar_w};
    assign w_colour    = bar_colour(r_bar);

    // restoring division, one quotient bit a cycle
    assign w_dt   = {r_drem, r_dvd[DVD_W-1]};
    assign w_dge  = w_dt >= {1'b0, r_dbw};
    assign w_dsub = w_dt - {1'b0, r_dbw};

    assign w_scroll_sum = 16'(r_dq) * 16'(r_dbw) + 16'(r_drem);
    assign w_pos_sum    = 16'({r_col, 1'b0}) + 16'(r_scroll);

    assign o_status.active   = r_active;
    assign o_status.dirty    = r_dirty;
    assign o_status.div_done = (r_dcnt == DCNT_W'(DIV_STEPS - 1));
    assign o_status.out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_active    = r_active;
        n_chroma    = r_chroma;
        n_dirty     = r_dirty;
        n_svalid    = r_svalid;
        n_out_valid = r_out_valid;
        n_dcnt      = r_dcnt;
        n_row       = r_row;
        n_col       = r_col;
        n_scroll    = r_scroll;
        n_offset    = r_offset;
        n_bar       = r_bar;
        n_rem       = r_rem;
        n_sbar      = r_sbar;
        n_srem      = r_srem;
        n_dvd       = r_dvd;
        n_drem      = r_drem;
        n_dq        = r_dq;
        n_dbw       = r_dbw;
        n_plane     = r_plane;
        n_ob_offset = r_ob_offset;
        n_first     = r_first;
        n_second    = r_second;
        n_last      = r_last;

        if (i_out_ready) begin
            n_out_valid = 1'b0;
        end

        if (i_cmd.accept_start) begin
            n_active = 1'b1;
            n_chroma = 1'b0;
            n_row    = '0;
            n_col    = '0;
            n_offset = '0;
            n_dirty  = 1'b0;
            n_svalid = 1'b0;
            n_dvd    = DVD_W'(i_frame_number) * DVD_W'(i_geom.scroll_step);
            n_dbw    = i_geom.bar_w;
            n_drem   = '0;
            n_dq     = '0;
            n_dcnt   = '0;
        end

        if (i_cmd.div_load_resync) begin
            n_dvd   = DVD_W'(w_pos_sum);
            n_dbw   = i_geom.bar_w;
            n_drem  = '0;
            n_dq    = '0;
            n_dcnt  = '0;
            n_dirty = 1'b0;
        end

        if (i_cmd.div_step) begin
            n_dvd  = {r_dvd[DVD_W-2:0], 1'b0};
            n_drem = w_dge ? w_dsub[DIM_W-1:0] : w_dt[DIM_W-1:0];
            n_dq   = {r_dq[1:0], w_dge};
            n_dcnt = r_dcnt + DCNT_W'(1);
        end

        if (i_cmd.fin_start) begin
            // scroll phase rebuilt from quotient mod 8 and remainder
            n_scroll = w_scroll_sum[SCROLL_W-1:0];
            n_bar    = r_dq;
            n_rem    = r_drem;
            n_sbar   = r_dq;
            n_srem   = r_drem;
            n_svalid = !r_dirty;
        end

        if (i_cmd.fin_resync) begin
            n_bar = r_dq;
            n_rem = r_drem;
            if (r_col == '0) begin
                n_sbar   = r_dq;
                n_srem   = r_drem;
                n_svalid = !r_dirty;
            end
        end

        if (w_beat) begin
            n_out_valid = 1'b1;
            n_plane     = r_chroma ? PLANE_CHROMA : PLANE_LUMA;
            n_ob_offset = r_offset;
            n_first     = r_chroma ? w_colour.u : w_colour.y;
            n_second    = r_chroma ? w_colour.v : w_colour.y;
            n_last      = w_plane_end && r_chroma;
            n_offset    = r_offset + OFFSET_W'(2);

            if (!w_row_end) begin
                n_col = w_col_inc[PAIR_W-1:0];
                if (i_geom.bar_w == DIM_W'(1)) begin
                    n_bar = r_bar + 3'd2;
                end else if (w_bar_wrap) begin
                    n_rem = w_rem2[DIM_W-1:0] - i_geom.bar_w;
                    n_bar = r_bar + 3'd1;
                end else begin
                    n_rem = w_rem2[DIM_W-1:0];
                end
            end else begin
                n_col = '0;
                // row start phase is cached; recompute if the bar width moved
                if (r_svalid) begin
                    n_bar = r_sbar;
                    n_rem = r_srem;
                end else begin
                    n_dirty = 1'b1;
                end
                if (!w_plane_end) begin
                    n_row = w_row_inc[ROW_W-1:0];
                end else begin
                    n_row = '0;
                    if (r_chroma) begin
                        n_active = 1'b0;
                        n_chroma = 1'b0;
                    end else begin
                        n_chroma = 1'b1;
                    end
                end
            end
        end

        if (i_geom.bar_w_wr) begin
            n_dirty  = 1'b1;
            n_svalid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_chroma    <= 1'b0;
            r_dirty     <= 1'b0;
            r_svalid    <= 1'b0;
            r_out_valid <= 1'b0;
            r_dcnt      <= '0;
            r_row       <= '0;
            r_col       <= '0;
            r_scroll    <= '0;
            r_offset    <= '0;
        end else begin
            r_active    <= n_active;
            r_chroma    <= n_chroma;
            r_dirty     <= n_dirty;
            r_svalid    <= n_svalid;
            r_out_valid <= n_out_valid;
            r_dcnt      <= n_dcnt;
            r_row       <= n_row;
            r_col       <= n_col;
            r_scroll    <= n_scroll;
            r_offset    <= n_offset;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bar       <= n_bar;
        r_rem       <= n_rem;
        r_sbar      <= n_sbar;
        r_srem      <= n_srem;
        r_dvd       <= n_dvd;
        r_drem      <= n_drem;
        r_dq        <= n_dq;
        r_dbw       <= n_dbw;
        r_plane     <= n_plane;
        r_ob_offset <= n_ob_offset;
        r_first     <= n_first;
        r_second    <= n_second;
        r_last      <= n_last;
    end

    assign o_out_valid     = r_out_valid;
    assign o_plane         = r_plane;
    assign o_byte_offset   = r_ob_offset;
    assign o_first_byte    = r_first;
    assign o_second_byte   = r_second;
    assign o_last_of_frame = r_last;

endmodule

// File: src/scrolling_color_bar_nv12_generator_unit.sv
`timescale 1ns / 1ps
// top level of the scrolling colour bar nv12 generator: registers, controller, datapath
//
//  channel   direction  handshake                  word
//  in        sink       i_in_valid / o_in_ready    i_action, i_frame_number
//  out       source     o_out_valid / i_out_ready  o_plane, o_byte_offset, o_first_byte,
//                                                  o_second_byte, o_last_of_frame
//  cfg       sink       i_cfg_we (no wait)         i_cfg_index, i_cfg_data
//
// a beat word's result sits in the output register the next cycle
// and a further beat is taken in the same cycle that result is taken
// a start word runs the bit-serial remainder of frame_number * scroll_step by bar_width
// in S_DIV_START, then loads the bar phase in S_FIN_START
// a bar_width write drops the cached phase; with a frame open it is recomputed through the
// same divider, and unless that frame sits at a row start a second recompute follows its
// next row end, o_in_ready low throughout
// synchronous active-low reset clears the counters and returns the registers to
// 1280 x 720, bars of 160 pixels, scroll step 4
module scrolling_color_bar_nv12_generator_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // input words
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic                              i_action,
    input  logic [scb_pkg::FN_W-1:0]          i_frame_number,
    // output words
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic                              o_plane,
    output logic [scb_pkg::OFFSET_W-1:0]      o_byte_offset,
    output logic [7:0]                        o_first_byte,
    output logic [7:0]                        o_second_byte,
    output logic                              o_last_of_frame,
    // register writes
    input  logic                              i_cfg_we,
    input  logic [scb_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [scb_pkg::DIM_W-1:0]         i_cfg_data
);
    import scb_pkg::*;

    logic [DIM_W-1:0]  r_frame_width;
    logic [DIM_W-1:0]  r_frame_height;
    logic [DIM_W-1:0]  r_bar_width;
    logic [STEP_W-1:0] r_scroll_step;

    logic [DIM_W-1:0]  w_w_even;
    logic [DIM_W-1:0]  w_h_even;
    logic [DIM_W-1:0]  w_w_eff;
    logic [DIM_W-1:0]  w_h_eff;
    logic [DIM_W-1:0]  w_bw_eff;

    t_geom   w_geom;
    t_cmd    w_cmd;
    t_status w_status;

    // register file, written without wait
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= DIM_W'(1280);
            r_frame_height <= DIM_W'(720);
            r_bar_width    <= DIM_W'(160);
            r_scroll_step  <= STEP_W'(4);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_FRAME_WIDTH:  r_frame_width  <= i_cfg_data;
                REG_FRAME_HEIGHT: r_frame_height <= i_cfg_data;
                REG_BAR_WIDTH:    r_bar_width    <= i_cfg_data;
                REG_SCROLL_STEP:  r_scroll_step  <= i_cfg_data[STEP_W-1:0];
                default:          r_scroll_step  <= r_scroll_step;
            endcase
        end
    end

    // dimensions: low bit dropped, floor of 2, ceiling at the maximum
    assign w_w_even = {r_frame_width[DIM_W-1:1], 1'b0};
    assign w_h_even = {r_frame_height[DIM_W-1:1], 1'b0};

    always_comb begin
        if (w_w_even < DIM_W'(2)) begin
            w_w_eff = DIM_W'(2);
        end else if (w_w_even > DIM_W'(MAX_WIDTH)) begin
            w_w_eff = DIM_W'(MAX_WIDTH) & ~DIM_W'(1);
        end else begin
            w_w_eff = w_w_even;
        end

        if (w_h_even < DIM_W'(2)) begin
            w_h_eff = DIM_W'(2);
        end else if (w_h_even > DIM_W'(MAX_HEIGHT)) begin
            w_h_eff = DIM_W'(MAX_HEIGHT) & ~DIM_W'(1);
        end else begin
            w_h_eff = w_h_even;
        end

        // zero-width bars count as one pixel
        if (r_bar_width == '0) begin
            w_bw_eff = DIM_W'(1);
        end else if (r_bar_width > DIM_W'(BAR_MAX)) begin
            w_bw_eff = DIM_W'(BAR_MAX);
        end else begin
            w_bw_eff = r_bar_width;
        end
    end

    assign w_geom.pairs       = w_w_eff[DIM_W-1:1];
    assign w_geom.rows_luma   = w_h_eff;
    assign w_geom.rows_chroma = w_h_eff[DIM_W-1:1];
    assign w_geom.bar_w       = w_bw_eff;
    assign w_geom.scroll_step = r_scroll_step;
    assign w_geom.bar_w_wr    = i_cfg_we && (i_cfg_index == REG_BAR_WIDTH);

    scb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_action   (i_action),
        .o_in_ready (o_in_ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    scb_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_status        (w_status),
        .i_geom          (w_geom),
        .i_frame_number  (i_frame_number),
        .i_out_ready     (i_out_ready),
        .o_out_valid     (o_out_valid),
        .o_plane         (o_plane),
        .o_byte_offset   (o_byte_offset),
        .o_first_byte    (o_first_byte),
        .o_second_byte   (o_second_byte),
        .o_last_of_frame (o_last_of_frame)
    );

endmodule

// File: bench/nv12_beat_checker.sv
`timescale 1ns / 1ps
// checker for the colour bar generator: tracks registers and input words, predicts and compares beats
module nv12_beat_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    input  logic                              i_in_ready,
    input  logic                              i_action,
    input  logic [scb_pkg::FN_W-1:0]          i_frame_number,
    input  logic                              i_out_valid,
    input  logic                              i_out_ready,
    input  logic                              i_plane,
    input  logic [scb_pkg::OFFSET_W-1:0]      i_byte_offset,
    input  logic [7:0]                        i_first_byte,
    input  logic [7:0]                        i_second_byte,
    input  logic                              i_last_of_frame,
    input  logic                              i_cfg_we,
    input  logic [scb_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [scb_pkg::DIM_W-1:0]         i_cfg_data,
    output int                                o_mismatches,
    output int                                o_pending
);

    typedef struct packed {
        logic                         plane;
        logic [scb_pkg::OFFSET_W-1:0] offset;
        logic [7:0]                   byte0;
        logic [7:0]                   byte1;
        logic                         ends_frame;
    } nv12_beat_t;

    nv12_beat_t predicted_beats[$];

    logic [scb_pkg::DIM_W-1:0]  reg_width;
    logic [scb_pkg::DIM_W-1:0]  reg_height;
    logic [scb_pkg::DIM_W-1:0]  reg_bar;
    logic [scb_pkg::STEP_W-1:0] reg_step;

    logic                          frame_on;
    logic                          in_chroma;
    int unsigned                   row_idx;
    int unsigned                   pair_idx;
    int unsigned                   scroll;
    logic [scb_pkg::OFFSET_W-1:0]  next_offset;

    // bar colours: r off for bit 1, g off for bit 2, b off for bit 0
    function automatic logic [7:0] bt601(input int kr, input int kg, input int kb,
                                         input logic [2:0] bar, input int bias);
        int r, g, b, s, v;
        r = bar[1] ? 16 : 235;
        g = bar[2] ? 16 : 235;
        b = bar[0] ? 16 : 235;
        s = kr * r + kg * g + kb * b + 128 + 65536;
        v = (s >>> 8) - 256 + bias;
        if (v < 0) v = 0;
        if (v > 255) v = 255;
        return v[7:0];
    endfunction

    function automatic int unsigned clip_dim(input logic [scb_pkg::DIM_W-1:0] raw,
                                             input int unsigned ceiling);
        int unsigned v;
        v = {raw[scb_pkg::DIM_W-1:1], 1'b0};
        if (v < 2) v = 2;
        if (v > ceiling) v = ceiling - (ceiling % 2);
        return v;
    endfunction

    always @(posedge i_clk) begin : track
        nv12_beat_t      want;
        int unsigned     w, h, bw, period, pairs, rows, col;
        longint unsigned product;
        logic [2:0]      bar;
        logic            row_end, plane_end;
        if (!i_rst_n) begin
            reg_width    = 13'd1280;
            reg_height   = 13'd720;
            reg_bar      = 13'd160;
            reg_step     = 8'd4;
            frame_on     = 1'b0;
            in_chroma    = 1'b0;
            row_idx      = 0;
            pair_idx     = 0;
            scroll       = 0;
            next_offset  = '0;
            o_mismatches = 0;
            predicted_beats.delete();
        end else begin
            // outgoing beat against the oldest prediction
            if (i_out_valid && i_out_ready) begin
                if (predicted_beats.size() == 0) begin
                    $error("unexpected beat: offset %0d, bytes %0d %0d",
                           i_byte_offset, i_first_byte, i_second_byte);
                    o_mismatches++;
                end else begin
                    want = predicted_beats.pop_front();
                    if (i_plane !== want.plane) begin
                        $error("plane: expected %0d, got %0d", want.plane, i_plane);
                        o_mismatches++;
                    end
                    if (i_byte_offset !== want.offset) begin
                        $error("byte_offset: expected %0d, got %0d", want.offset, i_byte_offset);
                        o_mismatches++;
                    end
                    if (i_first_byte !== want.byte0) begin
                        $error("first_byte: expected %0d, got %0d", want.byte0, i_first_byte);
                        o_mismatches++;
                    end
                    if (i_second_byte !== want.byte1) begin
                        $error("second_byte: expected %0d, got %0d", want.byte1, i_second_byte);
                        o_mismatches++;
                    end
                    if (i_last_of_frame !== want.ends_frame) begin
                        $error("last_of_frame: expected %0d, got %0d",
                               want.ends_frame, i_last_of_frame);
                        o_mismatches++;
                    end
                end
            end

            if (i_cfg_we) begin
                case (i_cfg_index)
                    scb_pkg::REG_FRAME_WIDTH:  reg_width  = i_cfg_data;
                    scb_pkg::REG_FRAME_HEIGHT: reg_height = i_cfg_data;
                    scb_pkg::REG_BAR_WIDTH:    reg_bar    = i_cfg_data;
                    default:                   reg_step   = i_cfg_data[scb_pkg::STEP_W-1:0];
                endcase
            end

            if (i_in_valid && i_in_ready) begin
                w  = clip_dim(reg_width, scb_pkg::MAX_WIDTH);
                h  = clip_dim(reg_height, scb_pkg::MAX_HEIGHT);
                bw = (reg_bar == 0) ? 1 : ((reg_bar > scb_pkg::BAR_MAX) ? scb_pkg::BAR_MAX : reg_bar);
                period = 8 * bw;
                if (i_action == scb_pkg::ACT_START) begin
                    // new frame, abandons any frame in progress
                    frame_on    = 1'b1;
                    in_chroma   = 1'b0;
                    row_idx     = 0;
                    pair_idx    = 0;
                    next_offset = '0;
                    product     = i_frame_number;
                    product     = product * reg_step;
                    scroll      = product % period;
                end else if (frame_on) begin
                    col   = (pair_idx * 2) & 32'hFFFF;
                    bar   = 3'(((col + scroll) % period) / bw);
                    pairs = w / 2;
                    rows  = in_chroma ? h / 2 : h;
                    row_end   = (pair_idx + 1 >= pairs);
                    plane_end = row_end && (row_idx + 1 >= rows);

                    want.plane      = in_chroma ? scb_pkg::PLANE_CHROMA : scb_pkg::PLANE_LUMA;
                    want.offset     = next_offset;
                    want.byte0      = in_chroma ? bt601(-38, -74, 112, bar, 128)
                                                : bt601(66, 129, 25, bar, 16);
                    want.byte1      = in_chroma ? bt601(112, -94, -18, bar, 128) : want.byte0;
                    want.ends_frame = plane_end && in_chroma;
                    predicted_beats.push_back(want);

                    next_offset = next_offset + 2;
                    if (!row_end) begin
                        pair_idx++;
                    end else begin
                        pair_idx = 0;
                        if (!plane_end) begin
                            row_idx++;
                        end else begin
                            row_idx = 0;
                            if (in_chroma) begin
                                frame_on  = 1'b0;
                                in_chroma = 1'b0;
                            end else begin
                                in_chroma = 1'b1;
                            end
                        end
                    end
                end
            end
        end
        o_pending = predicted_beats.size();
    end

endmodule

// File: bench/tb_scrolling_color_bar_nv12_generator_unit.sv
`timescale 1ns / 1ps
// testbench top of the colour bar generator: clock, reset, stimulus, receiver stalls and verdict
module tb_scrolling_color_bar_nv12_generator_unit;
    import scb_pkg::*;

    localparam int     CLK_PERIOD    = 8;
    localparam int     RESET_CYCLES  = 8;
    localparam int     RANDOM_ITEMS  = 1150;
    // a start word or a bar width write keeps the divider busy
    localparam int     SETTLE_CYCLES = 64;
    localparam int     LONG_HOLD     = 400;
    localparam int     HOLD_AFTER    = 300;
    // frames bigger than this are only ever run part of the way
    localparam int     BIG_FRAME     = 400;
    localparam longint LIMIT_NS      = 4_000_000;

    typedef enum {RX_OPEN, RX_HALF, RX_RARE, RX_COMB} rx_mode_e;
    typedef enum {SEQ_FULL, SEQ_PARTIAL, SEQ_RESUME, SEQ_NOISE} seq_kind_e;

    logic                    clk             = 1'b0;
    logic                    rst_n           = 1'b0;
    logic                    in_valid        = 1'b0;
    logic                    in_ready;
    logic                    in_action       = ACT_BEAT;
    logic [FN_W-1:0]         in_frame_number = '0;
    logic                    out_valid;
    logic                    out_ready       = 1'b0;
    logic                    out_plane;
    logic [OFFSET_W-1:0]     out_byte_offset;
    logic [7:0]              out_first_byte;
    logic [7:0]              out_second_byte;
    logic                    out_last_of_frame;
    logic                    cfg_we          = 1'b0;
    logic [CFG_IDX_W-1:0]    cfg_index       = REG_FRAME_WIDTH;
    logic [DIM_W-1:0]        cfg_data        = '0;
    int                      mismatches;
    int                      pending;

    // what the stimulus last wrote, used only to size the frames it sends
    logic [DIM_W-1:0]        sh_width  = 13'd1280;
    logic [DIM_W-1:0]        sh_height = 13'd720;

    // sender burst state
    int                      burst_left = 0;

    // receiver state
    rx_mode_e                rx_mode    = RX_OPEN;
    int                      mode_left  = 0;
    int                      comb_phase = 0;
    int                      hold_left  = 0;
    bit                      hold_req   = 1'b0;
    bit                      hold_done  = 1'b0;

    always #(CLK_PERIOD / 2) clk = ~clk;

    scrolling_color_bar_nv12_generator_unit dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .o_in_ready      (in_ready),
        .i_action        (in_action),
        .i_frame_number  (in_frame_number),
        .o_out_valid     (out_valid),
        .i_out_ready     (out_ready),
        .o_plane         (out_plane),
        .o_byte_offset   (out_byte_offset),
        .o_first_byte    (out_first_byte),
        .o_second_byte   (out_second_byte),
        .o_last_of_frame (out_last_of_frame),
        .i_cfg_we        (cfg_we),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    nv12_beat_checker u_checker (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .i_in_ready      (in_ready),
        .i_action        (in_action),
        .i_frame_number  (in_frame_number),
        .i_out_valid     (out_valid),
        .i_out_ready     (out_ready),
        .i_plane         (out_plane),
        .i_byte_offset   (out_byte_offset),
        .i_first_byte    (out_first_byte),
        .i_second_byte   (out_second_byte),
        .i_last_of_frame (out_last_of_frame),
        .i_cfg_we        (cfg_we),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data),
        .o_mismatches    (mismatches),
        .o_pending       (pending)
    );

    // receiver: changes pattern every so often, plus one long hold-off on request
    always @(negedge clk) begin
        if (hold_req && !hold_done) begin
            hold_left = LONG_HOLD;
            hold_done = 1'b1;
        end
        if (hold_left != 0) begin
            hold_left--;
            out_ready <= 1'b0;
        end else begin
            if (mode_left == 0) begin
                rx_mode   = rx_mode_e'($urandom_range(0, 3));
                mode_left = $urandom_range(16, 200);
            end
            mode_left--;
            comb_phase++;
            case (rx_mode)
                RX_OPEN: out_ready <= 1'b1;
                RX_HALF: out_ready <= 1'($urandom_range(0, 1));
                RX_RARE: out_ready <= ($urandom_range(0, 7) == 0);
                default: out_ready <= (comb_phase % 3 != 0);
            endcase
        end
    end

    // one input word, offered at a falling edge and held until taken;
    // bursts of random length with random gaps, now and then a long gapless stretch
    task automatic send_word(input logic act, input logic [FN_W-1:0] fn);
        int gap;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 32);
            gap        = $urandom_range(0, 8);
            if (gap != 0) begin
                @(negedge clk);
                in_valid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        burst_left--;
        @(negedge clk);
        in_valid        <= 1'b1;
        in_action       <= act;
        in_frame_number <= fn;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    // drop valid, wait for every predicted beat, then let the divider finish
    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
    endtask

    // bar width goes last so its phase recompute does not overlap other writes
    task automatic program_regs(input logic [3:0] which, input logic [DIM_W-1:0] w,
                                input logic [DIM_W-1:0] h, input logic [DIM_W-1:0] bw,
                                input logic [DIM_W-1:0] step);
        if (which[REG_FRAME_WIDTH]) begin
            write_reg(REG_FRAME_WIDTH, w);
            sh_width = w;
        end
        if (which[REG_FRAME_HEIGHT]) begin
            write_reg(REG_FRAME_HEIGHT, h);
            sh_height = h;
        end
        if (which[REG_SCROLL_STEP]) write_reg(REG_SCROLL_STEP, step);
        if (which[REG_BAR_WIDTH]) write_reg(REG_BAR_WIDTH, bw);
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // beats in one whole frame: luma rows plus the half-height chroma rows
    function automatic int unsigned frame_size();
        int unsigned w, h;
        w = {sh_width[DIM_W-1:1], 1'b0};
        h = {sh_height[DIM_W-1:1], 1'b0};
        if (w < 2) w = 2;
        if (w > MAX_WIDTH) w = MAX_WIDTH;
        if (h < 2) h = 2;
        if (h > MAX_HEIGHT) h = MAX_HEIGHT;
        return (w / 2) * h + (w / 2) * (h / 2);
    endfunction

    // mostly small sizes, sometimes the clamped extremes or any 13-bit value
    function automatic logic [DIM_W-1:0] pick_dim(input int unsigned hi);
        case ($urandom_range(0, 15))
            0:       return 13'd0;
            1:       return 13'd1;
            2:       return 13'h1FFF;
            3:       return 13'd4096;
            4:       return 13'd4097;
            5:       return 13'($urandom);
            default: return 13'($urandom_range(2, hi));
        endcase
    endfunction

    function automatic logic [FN_W-1:0] pick_fn();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return $urandom;
        endcase
    endfunction

    initial begin : stimulus
        int unsigned     total, beats, pick, n;
        int              useful;
        bit              frame_open;
        seq_kind_e       kind;
        logic [DIM_W-1:0] step;
        useful     = 0;
        frame_open = 1'b0;

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: beat with no frame open is dropped
        send_word(ACT_BEAT, '1);
        // default geometry, zero frame number
        send_word(ACT_START, '0);
        repeat (2) send_word(ACT_BEAT, '0);
        settle();

        // zero width, height and bar width clamp up; largest step with largest frame number
        program_regs(4'b1111, 13'd0, 13'd0, 13'd0, 13'd255);
        send_word(ACT_START, '1);
        repeat (3) send_word(ACT_BEAT, '0);
        // frame is over, this one is dropped
        send_word(ACT_BEAT, '0);
        // restart in the middle of a frame
        send_word(ACT_START, 32'd5);
        send_word(ACT_BEAT, '0);
        send_word(ACT_START, 32'd7);
        repeat (3) send_word(ACT_BEAT, '0);
        settle();

        // oversized registers clamp down; frame left open
        program_regs(4'b0111, 13'h1FFF, 13'h1FFF, 13'h1FFF, 13'd0);
        send_word(ACT_START, $urandom);
        repeat (3) send_word(ACT_BEAT, '0);
        settle();

        // geometry shrinks under the open frame, which then runs on to its end
        program_regs(4'b1111, 13'd1, 13'd3, 13'd4096, 13'd0);
        repeat (3) send_word(ACT_BEAT, '0);
        send_word(ACT_START, 32'd9);
        repeat (4) send_word(ACT_BEAT, '0);

        // random part
        while (useful < RANDOM_ITEMS) begin
            settle();
            if ($urandom_range(0, 2) != 0) begin
                case ($urandom_range(0, 7))
                    0:       step = 13'd0;
                    1:       step = 13'd255;
                    default: step = 13'($urandom);
                endcase
                program_regs(4'($urandom_range(1, 15)), pick_dim(16), pick_dim(8),
                             pick_dim(12), step);
            end
            total = frame_size();
            pick  = $urandom_range(0, 9);
            kind  = (pick < 6) ? SEQ_FULL : (pick < 8) ? SEQ_PARTIAL :
                    (pick < 9) ? SEQ_RESUME : SEQ_NOISE;
            case (kind)
                SEQ_FULL: begin
                    send_word(ACT_START, pick_fn());
                    useful++;
                    // long receiver hold while words keep coming
                    if (useful >= HOLD_AFTER) hold_req = 1'b1;
                    frame_open = (total > BIG_FRAME);
                    beats = frame_open ? $urandom_range(10, 60) : total;
                    repeat (beats) send_word(ACT_BEAT, $urandom);
                    useful += beats;
                    // beats after the frame has ended are dropped
                    if (!frame_open) repeat ($urandom_range(0, 2)) send_word(ACT_BEAT, $urandom);
                end
                SEQ_PARTIAL: begin
                    send_word(ACT_START, pick_fn());
                    beats = $urandom_range(1, (total - 1 > 60) ? 60 : total - 1);
                    repeat (beats) send_word(ACT_BEAT, $urandom);
                    useful += beats + 1;
                    frame_open = 1'b1;
                end
                SEQ_RESUME: begin
                    // beats without a start: continue an open frame, or are dropped
                    beats = $urandom_range(1, 30);
                    repeat (beats) send_word(ACT_BEAT, $urandom);
                    if (frame_open) useful += beats;
                    frame_open = 1'b0;
                end
                default: begin
                    n = $urandom_range(1, 8);
                    repeat (n) send_word(1'($urandom_range(0, 1)), pick_fn());
                    useful += n;
                    frame_open = 1'b1;
                end
            endcase
        end

        settle();
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial begin : watchdog
        #(LIMIT_NS);
        $display("== FAIL ==");
        $finish;
    end

endmodule

// File: sim.f
src/scb_pkg.sv
src/scb_ctrl.sv
src/scb_dp.sv
src/scrolling_color_bar_nv12_generator_unit.sv
bench/nv12_beat_checker.sv
bench/tb_scrolling_color_bar_nv12_generator_unit.sv
